// ----- sv/slfp_pkg.sv -----
`default_nettype none

package slfp_pkg;

  localparam int unsigned PosW = 24;
  localparam int unsigned LenW = 32;
  localparam int unsigned TypeW = 16;

  // Sync pattern, first byte on the wire first
  localparam logic [7:0] Sync0 = 8'hAB;
  localparam logic [7:0] Sync1 = 8'hCD;
  localparam logic [7:0] Sync2 = 8'hDC;
  localparam logic [7:0] Sync3 = 8'hBA;

  // Byte offsets inside a frame
  localparam logic [PosW-1:0] PosSync0 = 24'd0;
  localparam logic [PosW-1:0] PosSync1 = 24'd1;
  localparam logic [PosW-1:0] PosSync2 = 24'd2;
  localparam logic [PosW-1:0] PosSync3 = 24'd3;
  localparam logic [PosW-1:0] PosHdr = 24'd4;
  localparam logic [PosW-1:0] PosType0 = 24'd6;
  localparam logic [PosW-1:0] PosType1 = 24'd7;
  localparam logic [PosW-1:0] PosLen0 = 24'd8;
  localparam logic [PosW-1:0] PosLen1 = 24'd9;
  localparam logic [PosW-1:0] PosLen2 = 24'd10;
  localparam logic [PosW-1:0] PosLen3 = 24'd11;
  localparam logic [PosW-1:0] PosBody = 24'd12;

  localparam logic [LenW-1:0] MinLen = 32'd13;
  localparam logic [PosW-1:0] MaxLenReset = 24'd65536;

  // Known command types
  localparam logic [TypeW-1:0] CmdA = 16'h0001;
  localparam logic [TypeW-1:0] CmdB = 16'h0002;
  localparam logic [TypeW-1:0] CmdC = 16'h0004;
  localparam logic [TypeW-1:0] CmdD = 16'h0006;
  localparam logic [TypeW-1:0] CmdE = 16'h0008;
  localparam logic [TypeW-1:0] CmdF = 16'h000A;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [PosW-1:0]  byte_offset;
    logic             in_frame;
    logic             frame_end;
    logic [TypeW-1:0] frame_type;
    logic             type_known;
    logic [LenW-1:0]  frame_length;
    logic             length_error;
  } result_t;

  function automatic logic type_is_known(input logic [TypeW-1:0] t);
    return t inside {CmdA, CmdB, CmdC, CmdD, CmdE, CmdF};
  endfunction

endpackage

`default_nettype wire

// ----- sv/slfp_in_stage.sv -----
`default_nettype none

module slfp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       advance,
  output logic            s_valid,
  output logic [7:0]      s_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  // hold while the held item cannot move on
  assign in_stall = valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  assign s_valid = valid_r;
  assign s_byte  = byte_r;

endmodule

`default_nettype wire

// ----- sv/slfp_parse.sv -----
`default_nettype none

module slfp_parse (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire logic [7:0]                 rx_byte,
  input  wire logic [slfp_pkg::PosW-1:0]  max_len,
  output slfp_pkg::result_t               res
);

  logic [slfp_pkg::PosW-1:0]  pos_r, pos_nxt;
  logic [slfp_pkg::LenW-1:0]  len_r, len_nxt;
  logic [slfp_pkg::TypeW-1:0] type_r, type_nxt;
  logic [slfp_pkg::LenW-1:0]  len_cap;
  logic [slfp_pkg::PosW:0]    pos_inc;
  logic                       match;

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    type_nxt = type_r;
    len_cap  = {rx_byte, len_r[23:0]};
    pos_inc  = {1'b0, pos_r} + 25'd1;
    match    = 1'b0;

    res.data_byte    = rx_byte;
    res.byte_offset  = pos_r;
    res.in_frame     = 1'b1;
    res.frame_end    = 1'b0;
    res.frame_type   = '0;
    res.type_known   = 1'b0;
    res.frame_length = '0;
    res.length_error = 1'b0;

    case (pos_r)
      slfp_pkg::PosSync0: begin
        match = (rx_byte == slfp_pkg::Sync0);
        pos_nxt = match ? slfp_pkg::PosSync1 : slfp_pkg::PosSync0;
        res.in_frame = match;
      end
      slfp_pkg::PosSync1: begin
        match = (rx_byte == slfp_pkg::Sync1);
        pos_nxt = match ? slfp_pkg::PosSync2 : slfp_pkg::PosSync0;
        res.in_frame = match;
      end
      slfp_pkg::PosSync2: begin
        match = (rx_byte == slfp_pkg::Sync2);
        pos_nxt = match ? slfp_pkg::PosSync3 : slfp_pkg::PosSync0;
        res.in_frame = match;
      end
      slfp_pkg::PosSync3: begin
        match = (rx_byte == slfp_pkg::Sync3);
        pos_nxt = match ? slfp_pkg::PosHdr : slfp_pkg::PosSync0;
        res.in_frame = match;
      end
      slfp_pkg::PosType0: begin
        type_nxt = {type_r[15:8], rx_byte};
        pos_nxt = slfp_pkg::PosType1;
      end
      slfp_pkg::PosType1: begin
        type_nxt = {rx_byte, type_r[7:0]};
        pos_nxt = slfp_pkg::PosLen0;
      end
      slfp_pkg::PosLen0: begin
        len_nxt = {len_r[31:8], rx_byte};
        pos_nxt = slfp_pkg::PosLen1;
      end
      slfp_pkg::PosLen1: begin
        len_nxt = {len_r[31:16], rx_byte, len_r[7:0]};
        pos_nxt = slfp_pkg::PosLen2;
      end
      slfp_pkg::PosLen2: begin
        len_nxt = {len_r[31:24], rx_byte, len_r[15:0]};
        pos_nxt = slfp_pkg::PosLen3;
      end
      slfp_pkg::PosLen3: begin
        len_nxt = len_cap;
        res.frame_length = len_cap;
        if (len_cap < slfp_pkg::MinLen || len_cap > {8'd0, max_len}) begin
          res.length_error = 1'b1;
          pos_nxt = slfp_pkg::PosSync0;
        end else begin
          pos_nxt = slfp_pkg::PosBody;
        end
      end
      default: begin
        pos_nxt = pos_inc[slfp_pkg::PosW-1:0];
        if (pos_r >= slfp_pkg::PosBody) begin
          res.frame_length = len_r;
          if ({7'd0, pos_inc} == len_r) begin
            res.frame_end  = 1'b1;
            res.frame_type = type_r;
            res.type_known = slfp_pkg::type_is_known(type_r);
            pos_nxt = slfp_pkg::PosSync0;
          end
        end
      end
    endcase

    if (!res.in_frame) begin
      res.byte_offset = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      type_r <= '0;
    end else if (fire) begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      type_r <= type_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/slfp_out_stage.sv -----
`default_nettype none

module slfp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s_valid,
  input  wire slfp_pkg::result_t res,
  input  wire logic              out_stall,
  output logic                   advance,
  output logic                   out_valid,
  output slfp_pkg::result_t      out_res
);

  logic              valid_r;
  slfp_pkg::result_t res_r;

  // move on when the result register is empty or being drained
  assign advance = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ----- sv/sync_length_frame_parser.sv -----
`default_nettype none

// Byte-serial deframer. Each accepted input item is one received byte and
// yields exactly one result item, in order: the byte itself, its offset in
// the current frame and the frame flags. The block hunts for the sync
// pattern AB CD DC BA; a mismatch drops back to hunting and the failing
// byte is not retried as a first sync byte. Bytes 6-7 carry a little-endian
// type and bytes 8-11 a little-endian total length. On byte 11 a length
// below 13 or above cfg max_frame_length raises length_error and hunting
// resumes; otherwise the frame ends on the byte whose offset plus one
// equals the length, and that item carries the type and a flag for the six
// known commands (1, 2, 4, 6, 8, 10). Rate: one item per clock while the
// result is not stalled. Each byte passes through the input register, then
// the one-pass parse into the result register. out_stall holds the result
// register; the input stalls only while both registers are full and the
// result is stalled. Write max_frame_length (reset 65536) only while no
// items are in flight.
module sync_length_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_data_byte,
  output logic [23:0]      out_byte_offset,
  output logic             out_in_frame,
  output logic             out_frame_end,
  output logic [15:0]      out_frame_type,
  output logic             out_type_known,
  output logic [31:0]      out_frame_length,
  output logic             out_length_error
);

  logic [slfp_pkg::PosW-1:0]        max_len_val_r;
  logic                             advance;
  logic                             s_valid;
  logic [7:0]                       s_byte;
  slfp_pkg::result_t                res;
  slfp_pkg::result_t                out_res;

  // Maximum frame length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_val_r <= slfp_pkg::MaxLenReset;
    end else if (cfg_wr_en) begin
      max_len_val_r <= cfg_wr_data;
    end
  end

  // Input register: holds one byte while the result side stalls
  slfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .s_valid    (s_valid),
    .s_byte     (s_byte)
  );

  // Parser state and one-pass result logic; state advances as the item moves
  slfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s_valid && advance),
    .rx_byte (s_byte),
    .max_len (max_len_val_r),
    .res     (res)
  );

  // Result register
  slfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .res       (res),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_data_byte    = out_res.data_byte;
  assign out_byte_offset  = out_res.byte_offset;
  assign out_in_frame     = out_res.in_frame;
  assign out_frame_end    = out_res.frame_end;
  assign out_frame_type   = out_res.frame_type;
  assign out_type_known   = out_res.type_known;
  assign out_frame_length = out_res.frame_length;
  assign out_length_error = out_res.length_error;

`ifndef SYNTHESIS
  // A frame end is always a byte of the frame, at or past the body start
  a_end_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_in_frame && out_byte_offset >= slfp_pkg::PosBody)
    else $error("frame_end outside a frame body");

  // Length errors only on the last length byte, with the frame flag set
  a_lerr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_error |-> out_in_frame && out_byte_offset == slfp_pkg::PosLen3)
    else $error("length_error on the wrong byte");

  // Bytes outside a frame carry no offset, length or type
  a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_frame |->
      out_byte_offset == 24'd0 && out_frame_length == 32'd0 && !out_frame_end)
    else $error("hunting byte carries frame data");

  // Input stall only ever comes from a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire
